>>> rtl/ppr_pkg.sv
// Package for the ping-pong receive buffer: sizes, operation codes,
// mark and address types, and the bank memory request struct.
// No dependencies.
package ppr_pkg;

   localparam int BANK_BYTES = 16384;
   localparam int MARK_W     = $clog2(BANK_BYTES + 1);
   localparam int ADDR_W     = $clog2(2 * BANK_BYTES);
   localparam int CFG_W      = 15;
   localparam int AVAIL_W    = 15;
   localparam int RX_W       = 64;
   localparam int CONS_W     = 32;
   localparam int SZ_W       = ((CFG_W > MARK_W) ? CFG_W : MARK_W) + 1;

   localparam logic [CFG_W-1:0] BANK_SIZE_RESET = CFG_W'(1024 * 16);

   localparam logic OP_STORE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef logic [MARK_W-1:0] mark_type;
   typedef logic [ADDR_W-1:0] addr_type;

   typedef struct packed {
      logic       wr_en;
      logic       rd_en;
      addr_type   addr;
      logic [7:0] wdata;
   } ram_req_type;

endpackage

>>> rtl/ppr_bank_ram.sv
// Single-port byte memory holding both banks, registered read data.
// Depends on ppr_pkg.
module ppr_bank_ram
   import ppr_pkg::*;
(
   input  logic        clock,
   input  ram_req_type ram_req,
   output logic [7:0]  rd_data
);

   logic [7:0] mem [2 * BANK_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.addr] <= ram_req.wdata;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ping_pong_receive_buffer_core.sv
// Ping-pong receive buffer: two byte banks with fill/consumed marks; uses ppr_pkg, ppr_bank_ram.
// A store request gives its response in the cycle after acceptance, a read
// request after its ST_READ state (registered read of the single-port bank memory).
// Throughput: one store per cycle unless rsp_stall holds it; no request is taken in ST_READ (memory read port).
// Reset (synchronous): marks, bank pointers, pending count and totals cleared,
// bank_size set to 16384; the bank memory is not cleared and needs no sweep.
module ping_pong_receive_buffer_core
   import ppr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic [7:0]         req_data_byte,
   input  logic               req_chunk_end,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_read_data,
   output logic               rsp_read_valid,
   output logic               rsp_write_accepted,
   output logic [AVAIL_W-1:0] rsp_bytes_available,
   output logic [RX_W-1:0]    rsp_total_received,
   output logic [CONS_W-1:0]  rsp_total_consumed,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CFG_W-1:0]   csr_bank_size
);

   typedef enum logic {ST_IDLE, ST_READ} state_type;

   state_type          state_ff, state_in;
   logic [CFG_W-1:0]   bank_size_ff;
   mark_type           fm_ff [2];
   mark_type           fm_in [2];
   mark_type           cm_ff [2];
   mark_type           cm_in [2];
   logic               fb_ff, fb_in;
   logic               rb_ff, rb_in;
   mark_type           pend_ff, pend_in;
   logic [RX_W-1:0]    rx_ff, rx_in;
   logic [CONS_W-1:0]  cons_ff, cons_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_read_data_ff, rsp_read_data_in;
   logic               rsp_read_valid_ff, rsp_read_valid_in;
   logic               rsp_write_accepted_ff, rsp_write_accepted_in;
   logic [AVAIL_W-1:0] rsp_avail_ff, rsp_avail_in;

   logic               req_accept;
   logic [SZ_W-1:0]    cfg_ext;
   logic [MARK_W:0]    size_use;
   logic [MARK_W:0]    pos;
   logic               fits;
   mark_type           pend_new;
   mark_type           c_cur;
   mark_type           c_next;
   mark_type           avail;
   ram_req_type        ram_req;
   logic [7:0]         ram_q;

   assign csr_ready  = 1'b1;
   assign req_stall  = (state_ff == ST_READ) | (rsp_valid_ff & rsp_stall);
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      cfg_ext = SZ_W'(bank_size_ff);
      if (cfg_ext == '0) begin
         size_use = (MARK_W + 1)'(1);
      end else if (cfg_ext > SZ_W'(BANK_BYTES)) begin
         size_use = (MARK_W + 1)'(BANK_BYTES);
      end else begin
         size_use = (MARK_W + 1)'(cfg_ext);
      end
   end

   ppr_bank_ram u_bank_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_q)
   );

   always_comb begin
      fm_in    = fm_ff;
      cm_in    = cm_ff;
      fb_in    = fb_ff;
      rb_in    = rb_ff;
      pend_in  = pend_ff;
      rx_in    = rx_ff;
      cons_in  = cons_ff;
      state_in = ST_IDLE;

      ram_req  = '0;
      ram_req.wdata = req_data_byte;

      pos      = {1'b0, fm_ff[fb_ff]} + {1'b0, pend_ff};
      fits     = pos < size_use;
      pend_new = fits ? pend_ff + mark_type'(1) : pend_ff;
      c_cur    = cm_ff[rb_ff];
      c_next   = c_cur + mark_type'(1);

      rsp_valid_in          = rsp_valid_ff & rsp_stall;
      rsp_read_data_in      = rsp_read_data_ff;
      rsp_read_valid_in     = rsp_read_valid_ff;
      rsp_write_accepted_in = rsp_write_accepted_ff;

      if (state_ff == ST_READ) begin
         rsp_valid_in     = 1'b1;
         rsp_read_data_in = rsp_read_valid_ff ? ram_q : 8'd0;
      end

      if (req_accept) begin
         rsp_read_valid_in     = 1'b0;
         rsp_write_accepted_in = 1'b0;
         rsp_read_data_in      = 8'd0;
         if (req_operation == OP_STORE) begin
            rsp_valid_in = 1'b1;
            ram_req.addr = addr_type'(pos) + (fb_ff ? addr_type'(BANK_BYTES) : '0);
            ram_req.wr_en = fits;
            rsp_write_accepted_in = fits;
            pend_in = pend_new;
            if (req_chunk_end && pend_new != '0) begin
               fm_in[fb_ff] = fm_ff[fb_ff] + pend_new;
               rx_in        = rx_ff + RX_W'(pend_new);
               pend_in      = '0;
               if ({1'b0, fm_in[fb_ff]} >= size_use || fb_ff == rb_ff) begin
                  if (~fb_ff != rb_ff) begin
                     fm_in[~fb_ff] = '0;
                     cm_in[~fb_ff] = '0;
                     if (cm_in[rb_ff] == fm_in[rb_ff]) begin
                        rb_in = ~rb_ff;
                     end
                     fb_in = ~fb_ff;
                  end
               end
            end
         end else begin
            state_in = ST_READ;
            ram_req.rd_en = 1'b1;
            ram_req.addr  = addr_type'(c_cur) + (rb_ff ? addr_type'(BANK_BYTES) : '0);
            if (pend_ff == '0 && fm_ff[rb_ff] > c_cur) begin
               rsp_read_valid_in = 1'b1;
               cons_in           = cons_ff + CONS_W'(1);
               cm_in[rb_ff]      = c_next;
               if (c_next == fm_ff[rb_ff]) begin
                  if (fb_ff == rb_ff) begin
                     cm_in[rb_ff] = '0;
                     fm_in[rb_ff] = '0;
                  end else begin
                     rb_in = ~rb_ff;
                  end
               end
            end
         end
      end

      avail = (fm_in[rb_in] > cm_in[rb_in]) ? fm_in[rb_in] - cm_in[rb_in] : '0;
      rsp_avail_in = req_accept ? AVAIL_W'(avail) : rsp_avail_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bank_size_ff <= BANK_SIZE_RESET;
         fm_ff[0]     <= '0;
         fm_ff[1]     <= '0;
         cm_ff[0]     <= '0;
         cm_ff[1]     <= '0;
         fb_ff        <= 1'b0;
         rb_ff        <= 1'b0;
         pend_ff      <= '0;
         rx_ff        <= '0;
         cons_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            bank_size_ff <= csr_bank_size;
         end
         fm_ff        <= fm_in;
         cm_ff        <= cm_in;
         fb_ff        <= fb_in;
         rb_ff        <= rb_in;
         pend_ff      <= pend_in;
         rx_ff        <= rx_in;
         cons_ff      <= cons_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_read_data_ff      <= rsp_read_data_in;
      rsp_read_valid_ff     <= rsp_read_valid_in;
      rsp_write_accepted_ff <= rsp_write_accepted_in;
      rsp_avail_ff          <= rsp_avail_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_data       = rsp_read_data_ff;
   assign rsp_read_valid      = rsp_read_valid_ff;
   assign rsp_write_accepted  = rsp_write_accepted_ff;
   assign rsp_bytes_available = rsp_avail_ff;
   assign rsp_total_received  = rx_ff;
   assign rsp_total_consumed  = cons_ff;

endmodule

>>> verif/tb.sv
// Testbench for ping_pong_receive_buffer_core: a scoreboard class predicts every
// response from the accepted requests, plain tasks drive the request and bank-size
// ports; responses are stalled at random. Depends on ppr_pkg and the core RTL.
`timescale 1ns / 1ps

module tb
   import ppr_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int MAX_PRINTS     = 40;

   typedef struct {
      logic [7:0]         read_data;
      logic               read_valid;
      logic               write_accepted;
      logic [AVAIL_W-1:0] bytes_available;
      logic [RX_W-1:0]    total_received;
      logic [CONS_W-1:0]  total_consumed;
   } buffer_rsp_type;

   class rx_buffer_scoreboard_type;
      bit [7:0]         bank_mem [2*BANK_BYTES];
      mark_type         fill_mark [2];
      mark_type         consumed_mark [2];
      bit               fill_bank;
      bit               read_bank;
      mark_type         pending;
      logic [RX_W-1:0]  rx_total;
      logic [CONS_W-1:0] cons_total;
      logic [CFG_W-1:0] bank_size;
      buffer_rsp_type   expected_rsp [$];
      int               mismatches;
      int               requests_noted;
      int               responses_checked;
      int               bytes_dropped;
      int               bytes_read;

      function new();
         fill_mark         = '{default: '0};
         consumed_mark     = '{default: '0};
         fill_bank         = 1'b0;
         read_bank         = 1'b0;
         pending           = '0;
         rx_total          = '0;
         cons_total        = '0;
         bank_size         = BANK_SIZE_RESET;
         mismatches        = 0;
         requests_noted    = 0;
         responses_checked = 0;
         bytes_dropped     = 0;
         bytes_read        = 0;
      endfunction

      function void set_bank_size(logic [CFG_W-1:0] v);
         bank_size = v;
      endfunction

      function int unsigned size_in_use();
         int unsigned s;
         s = bank_size;
         if (s == 0) s = 1;
         if (s > BANK_BYTES) s = BANK_BYTES;
         return s;
      endfunction

      function int unsigned read_bank_avail();
         int unsigned f;
         int unsigned c;
         f = fill_mark[read_bank];
         c = consumed_mark[read_bank];
         return (f > c) ? f - c : 0;
      endfunction

      function int outstanding();
         return expected_rsp.size();
      endfunction

      function void commit_chunk();
         bit fb;
         bit nxt;
         fb = fill_bank;
         if (pending == 0) return;
         fill_mark[fb] = fill_mark[fb] + pending;
         rx_total      = rx_total + RX_W'(pending);
         pending       = '0;
         if (fill_mark[fb] >= size_in_use() || fb == read_bank) begin
            nxt = ~fb;
            if (nxt != read_bank) begin
               fill_mark[nxt]     = '0;
               consumed_mark[nxt] = '0;
               if (consumed_mark[read_bank] == fill_mark[read_bank])
                  read_bank = ~read_bank;
               fill_bank = nxt;
            end
         end
      endfunction

      function void note_request(logic op, logic [7:0] data, logic cend);
         buffer_rsp_type exp;
         int unsigned pos;
         int unsigned c;
         bit          fb;
         bit          rb;
         exp = '{read_data: '0, read_valid: 1'b0, write_accepted: 1'b0,
                 bytes_available: '0, total_received: '0, total_consumed: '0};
         requests_noted++;
         if (op == OP_STORE) begin
            fb  = fill_bank;
            pos = fill_mark[fb] + pending;
            if (pos < size_in_use()) begin
               bank_mem[int'(fb) * BANK_BYTES + (pos % BANK_BYTES)] = data;
               pending = pending + 1'b1;
               exp.write_accepted = 1'b1;
            end else begin
               bytes_dropped++;
            end
            if (cend) commit_chunk();
         end else if (pending == 0 && read_bank_avail() > 0) begin
            rb = read_bank;
            c  = consumed_mark[rb];
            exp.read_data  = bank_mem[int'(rb) * BANK_BYTES + (c % BANK_BYTES)];
            exp.read_valid = 1'b1;
            bytes_read++;
            consumed_mark[rb] = MARK_W'(c + 1);
            cons_total = cons_total + 1'b1;
            if (consumed_mark[rb] == fill_mark[rb]) begin
               if (fill_bank == rb) begin
                  consumed_mark[rb] = '0;
                  fill_mark[rb]     = '0;
               end else begin
                  read_bank = ~rb;
               end
            end
         end
         exp.bytes_available = AVAIL_W'(read_bank_avail());
         exp.total_received  = rx_total;
         exp.total_consumed  = cons_total;
         expected_rsp.push_back(exp);
      endfunction

      task report(string msg);
         if (mismatches < MAX_PRINTS)
            $display("[%0t] MISMATCH response %0d: %s", $realtime, responses_checked, msg);
         mismatches++;
      endtask

      task check_response(logic [7:0] rdata, logic rvalid, logic accepted,
                          logic [AVAIL_W-1:0] avail, logic [RX_W-1:0] rx,
                          logic [CONS_W-1:0] cons);
         buffer_rsp_type exp;
         if (expected_rsp.size() == 0) begin
            report("response with no request outstanding");
            return;
         end
         exp = expected_rsp.pop_front();
         if (rdata !== exp.read_data)
            report($sformatf("read_data %h, expected %h", rdata, exp.read_data));
         if (rvalid !== exp.read_valid)
            report($sformatf("read_valid %b, expected %b", rvalid, exp.read_valid));
         if (accepted !== exp.write_accepted)
            report($sformatf("write_accepted %b, expected %b", accepted, exp.write_accepted));
         if (avail !== exp.bytes_available)
            report($sformatf("bytes_available %0d, expected %0d", avail,
                             exp.bytes_available));
         if (rx !== exp.total_received)
            report($sformatf("total_received %0d, expected %0d", rx, exp.total_received));
         if (cons !== exp.total_consumed)
            report($sformatf("total_consumed %0d, expected %0d", cons, exp.total_consumed));
         responses_checked++;
      endtask
   endclass

   logic               clock;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_stall;
   logic               req_operation  = OP_STORE;
   logic [7:0]         req_data_byte  = '0;
   logic               req_chunk_end  = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall      = 1'b0;
   logic [7:0]         rsp_read_data;
   logic               rsp_read_valid;
   logic               rsp_write_accepted;
   logic [AVAIL_W-1:0] rsp_bytes_available;
   logic [RX_W-1:0]    rsp_total_received;
   logic [CONS_W-1:0]  rsp_total_consumed;
   logic               csr_valid      = 1'b0;
   logic               csr_ready;
   logic [CFG_W-1:0]   csr_bank_size  = '0;

   rx_buffer_scoreboard_type sb = new();

   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int size_settings  = 0;
   int idle_cycles    = 0;

   ping_pong_receive_buffer_core u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_data_byte       (req_data_byte),
      .req_chunk_end       (req_chunk_end),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_read_data       (rsp_read_data),
      .rsp_read_valid      (rsp_read_valid),
      .rsp_write_accepted  (rsp_write_accepted),
      .rsp_bytes_available (rsp_bytes_available),
      .rsp_total_received  (rsp_total_received),
      .rsp_total_consumed  (rsp_total_consumed),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_bank_size       (csr_bank_size)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // response side: check accepted responses, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_read_data, rsp_read_valid, rsp_write_accepted,
                           rsp_bytes_available, rsp_total_received, rsp_total_consumed);
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("ping_pong_receive_buffer_core test failed");
      $finish;
   end

   task automatic send_request(logic op, logic [7:0] data, logic cend);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_data_byte <= data;
      req_chunk_end <= cend;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(op, data, cend);
   endtask

   task automatic write_bank_size(logic [CFG_W-1:0] v);
      csr_valid     <= 1'b1;
      csr_bank_size <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.set_bank_size(v);
      size_settings++;
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // chunks of stores with random content, bursts of reads, some noise and
   // chunks left open
   task automatic run_phase(logic [CFG_W-1:0] size, int mode, int count);
      int n;
      int win;
      int len;
      int pick;
      bit broken;
      n = 0;
      write_bank_size(size);
      win = sb.size_in_use() + 2;
      if (win > 24) win = 24;
      case (mode)
         0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_idle_pct = 61; rsp_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_stall_pct = 61; end
         default: begin send_idle_pct = 17; rsp_stall_pct = 17; end
      endcase
      while (n < count) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
            n++;
         end else if (pick < 6) begin
            len    = $urandom_range(1, win);
            broken = ($urandom_range(0, 7) == 0);
            for (int i = 0; i < len; i++) begin
               send_request(OP_STORE, 8'($urandom_range(0, 255)), (i == len - 1) && !broken);
               n++;
            end
         end else begin
            len = $urandom_range(1, win + 4);
            for (int i = 0; i < len; i++) begin
               send_request(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               n++;
            end
         end
      end
      drain_responses();
   endtask

   initial begin
      logic [CFG_W-1:0] sizes [10];
      sizes = '{15'd1, 15'd16384, 15'd0, 15'd32767, 15'd7, 15'd16, 15'd2, 15'd5, 15'd3,
                15'd13};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: four-byte banks
      write_bank_size(15'd4);
      send_request(OP_READ,  8'h3C, 1'b1);   // empty bank
      send_request(OP_STORE, 8'h00, 1'b0);
      send_request(OP_STORE, 8'hFF, 1'b0);
      send_request(OP_READ,  8'h00, 1'b0);   // chunk open
      send_request(OP_STORE, 8'hA5, 1'b1);   // commit, fill moves to bank 1
      send_request(OP_STORE, 8'h5A, 1'b0);
      send_request(OP_STORE, 8'h01, 1'b0);
      send_request(OP_STORE, 8'h80, 1'b0);
      send_request(OP_STORE, 8'h7F, 1'b1);   // bank 1 full
      send_request(OP_STORE, 8'h11, 1'b1);   // dropped, empty commit
      send_request(OP_STORE, 8'hEE, 1'b0);   // dropped
      for (int i = 0; i < 8; i++)
         send_request(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      send_request(OP_STORE, 8'hC3, 1'b1);
      send_request(OP_STORE, 8'h96, 1'b1);
      send_request(OP_READ,  8'hFF, 1'b1);
      send_request(OP_READ,  8'h00, 1'b0);
      send_request(OP_READ,  8'h00, 1'b0);
      drain_responses();

      for (int p = 0; p < 10; p++)
         run_phase(sizes[p], p % 4, 180);

      drain_responses();
      repeat (8) @(posedge clock);
      if (sb.outstanding() != 0) sb.report("responses still outstanding at end of run");

      $display("covered %0d requests and %0d responses over %0d bank-size settings",
               sb.requests_noted, sb.responses_checked, size_settings);
      $display("bytes read back: %0d, bytes dropped on full bank: %0d, mismatches: %0d",
               sb.bytes_read, sb.bytes_dropped, sb.mismatches);
      if (sb.mismatches == 0)
         $display("ping_pong_receive_buffer_core test passed");
      else
         $display("ping_pong_receive_buffer_core test failed");
      $finish;
   end

endmodule

>>> files.f
rtl/ppr_pkg.sv
rtl/ppr_bank_ram.sv
rtl/ping_pong_receive_buffer_core.sv
verif/tb.sv
